/* src/srfd_pkg.sv */
// Shared types and constants of the sensor range fault detector.
package srfd_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 8;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [SAMPLE_BITS-1:0] LOW_THR_RESET  = SAMPLE_BITS'(50);
    localparam logic [SAMPLE_BITS-1:0] HIGH_THR_RESET = SAMPLE_BITS'(4045);
    localparam logic [COUNT_BITS-1:0]  ASSERT_RESET   = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0]  RECOVER_RESET  = COUNT_BITS'(5);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LOW_THR     = 2'd0,
        CFG_HIGH_THR    = 2'd1,
        CFG_ASSERT_CNT  = 2'd2,
        CFG_RECOVER_CNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] low_thr;
        logic [SAMPLE_BITS-1:0] high_thr;
        logic [COUNT_BITS-1:0]  assert_cnt;
        logic [COUNT_BITS-1:0]  recover_cnt;
    } cfg_t;

    typedef struct packed {
        logic active;
        logic low;
        logic high;
    } lane_flags_t;

    typedef struct packed {
        logic [CHANNELS-1:0] fault_vec;
        logic [CHANNELS-1:0] low_vec;
        logic [CHANNELS-1:0] high_vec;
        logic                changed;
    } result_t;

endpackage

/* src/srfd_lane.sv */
// One channel: threshold compare, debounce run counters and fault flags.
module srfd_lane
    import srfd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   update,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  cfg_t                   cfg,
    output lane_flags_t            flags_cur,
    output lane_flags_t            flags_new
);

    logic [COUNT_BITS-1:0] bad_run_reg, bad_run_next;
    logic [COUNT_BITS-1:0] good_run_reg, good_run_next;
    lane_flags_t           flags_reg, flags_next;

    logic                  is_low;
    logic                  is_high;
    logic [COUNT_BITS-1:0] bad_inc;
    logic [COUNT_BITS-1:0] good_inc;

    assign is_low  = (sample <= cfg.low_thr);
    assign is_high = (sample >= cfg.high_thr);

    // Both counters saturate at their threshold, so the increment never wraps.
    assign bad_inc  = (bad_run_reg < cfg.assert_cnt) ? bad_run_reg + 1'b1 : bad_run_reg;
    assign good_inc = (good_run_reg < cfg.recover_cnt) ? good_run_reg + 1'b1 : good_run_reg;

    always_comb begin
        bad_run_next  = bad_run_reg;
        good_run_next = good_run_reg;
        flags_next    = flags_reg;
        if (is_low || is_high) begin
            good_run_next = '0;
            bad_run_next  = bad_inc;
            if (bad_inc >= cfg.assert_cnt) begin
                // Low wins when both thresholds are hit.
                flags_next.active = 1'b1;
                flags_next.low    = is_low;
                flags_next.high   = ~is_low;
            end
        end else begin
            bad_run_next = '0;
            if (flags_reg.active) begin
                if (good_inc >= cfg.recover_cnt) begin
                    flags_next    = '0;
                    good_run_next = '0;
                end else begin
                    good_run_next = good_inc;
                end
            end else begin
                good_run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bad_run_reg  <= '0;
            good_run_reg <= '0;
            flags_reg    <= '0;
        end else if (update) begin
            bad_run_reg  <= bad_run_next;
            good_run_reg <= good_run_next;
            flags_reg    <= flags_next;
        end
    end

    assign flags_cur = flags_reg;
    assign flags_new = flags_next;

endmodule

/* src/srfd_merge.sv */
// Gathers the lane flags into masks and the change flag, with a two-entry output buffer.
module srfd_merge
    import srfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  lane_flags_t flags_cur [CHANNELS],
    input  lane_flags_t flags_new [CHANNELS],
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_data
);

    result_t merged;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    take;

    logic [CHANNELS-1:0] cur_active, cur_low, cur_high;

    always_comb begin
        for (int i = 0; i < CHANNELS; i++) begin
            merged.fault_vec[i] = flags_new[i].active;
            merged.low_vec[i]   = flags_new[i].low;
            merged.high_vec[i]  = flags_new[i].high;
            cur_active[i]       = flags_cur[i].active;
            cur_low[i]          = flags_cur[i].low;
            cur_high[i]         = flags_cur[i].high;
        end
        merged.changed = (merged.fault_vec != cur_active) ||
                         (merged.low_vec != cur_low) ||
                         (merged.high_vec != cur_high);
    end

    assign take     = out_valid_reg && out_ready;
    assign in_ready = ~skid_valid_reg;

    // The skid entry fills only when the output entry is held by a stalled sink.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take) begin
            out_reg <= skid_valid_reg ? skid_reg : merged;
        end else if (in_valid && !skid_valid_reg) begin
            skid_reg <= merged;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* src/sensor_range_fault_detector.sv */
// Top level of the four-channel sensor range fault detector.
//
//  channel | ports                         | moves per transfer
//  --------+-------------------------------+----------------------------------
//  input   | s_valid / s_ready             | one sample per channel
//  result  | m_valid / m_ready             | active, low, high masks, changed
//  config  | cfg_valid / cfg_ready         | register index and write data
//
// One sample set is taken per cycle while s_ready is high; its result
// is registered. Four lanes update their counters in parallel, so the rate
// is set by the lane compare and counter logic while the input is not stalled.
// A two-entry output buffer lets one more item in while a result is stalled.
// Reset is synchronous, active low, and clears all counters and faults.
module sensor_range_fault_detector
    import srfd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [SAMPLE_BITS-1:0]  s_sample_ch0,
    input  logic [SAMPLE_BITS-1:0]  s_sample_ch1,
    input  logic [SAMPLE_BITS-1:0]  s_sample_ch2,
    input  logic [SAMPLE_BITS-1:0]  s_sample_ch3,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHANNELS-1:0]     m_fault_vec,
    output logic [CHANNELS-1:0]     m_low_vec,
    output logic [CHANNELS-1:0]     m_high_vec,
    output logic                    m_changed,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SAMPLE_BITS-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        accept;
    result_t     result;
    lane_flags_t flags_cur [CHANNELS];
    lane_flags_t flags_new [CHANNELS];
    logic [SAMPLE_BITS-1:0] samples [CHANNELS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.low_thr     <= LOW_THR_RESET;
            cfg_reg.high_thr    <= HIGH_THR_RESET;
            cfg_reg.assert_cnt  <= ASSERT_RESET;
            cfg_reg.recover_cnt <= RECOVER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOW_THR:     cfg_reg.low_thr     <= cfg_data;
                CFG_HIGH_THR:    cfg_reg.high_thr    <= cfg_data;
                CFG_ASSERT_CNT:  cfg_reg.assert_cnt  <= cfg_data[COUNT_BITS-1:0];
                CFG_RECOVER_CNT: cfg_reg.recover_cnt <= cfg_data[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign accept = s_valid && s_ready;

    assign samples[0] = s_sample_ch0;
    assign samples[1] = s_sample_ch1;
    assign samples[2] = s_sample_ch2;
    assign samples[3] = s_sample_ch3;

    for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
        srfd_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .update    (accept),
            .sample    (samples[i]),
            .cfg       (cfg_reg),
            .flags_cur (flags_cur[i]),
            .flags_new (flags_new[i])
        );
    end

    srfd_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (s_ready),
        .flags_cur (flags_cur),
        .flags_new (flags_new),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (result)
    );

    assign m_fault_vec = result.fault_vec;
    assign m_low_vec   = result.low_vec;
    assign m_high_vec  = result.high_vec;
    assign m_changed   = result.changed;

`ifndef SYNTHESIS
    a_cause_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_low_vec & m_high_vec) == '0))
        else $error("fault reported with both low and high cause");

    a_cause_matches_active: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_low_vec | m_high_vec) == m_fault_vec))
        else $error("active mask does not match the fault causes");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled while no result is pending");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("accepted item produced no result");
`endif

endmodule

/* tb/sv/sensor_range_fault_detector_test.sv */
// Self-checking testbench of the sensor range fault detector, with its own fault predictor.
`timescale 1ns / 1ps

module sensor_range_fault_detector_test;
    import srfd_pkg::*;

    localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
    localparam int REPORT_LIMIT = 10;

    typedef enum int {
        RUN_LOW,
        RUN_HIGH,
        RUN_GOOD,
        RUN_NOISE
    } run_kind_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [SAMPLE_BITS-1:0]  s_sample_ch0;
    logic [SAMPLE_BITS-1:0]  s_sample_ch1;
    logic [SAMPLE_BITS-1:0]  s_sample_ch2;
    logic [SAMPLE_BITS-1:0]  s_sample_ch3;
    logic                    m_valid;
    logic                    m_ready;
    logic [CHANNELS-1:0]     m_fault_vec;
    logic [CHANNELS-1:0]     m_low_vec;
    logic [CHANNELS-1:0]     m_high_vec;
    logic                    m_changed;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [SAMPLE_BITS-1:0]  cfg_data;

    // Predictor state: register copy, run counters and fault flags per channel.
    cfg_t                 shadow_cfg;
    logic [COUNT_BITS-1:0] bad_count [CHANNELS];
    logic [COUNT_BITS-1:0] good_count [CHANNELS];
    logic [CHANNELS-1:0]   fault_active;
    logic [CHANNELS-1:0]   fault_low;
    logic [CHANNELS-1:0]   fault_high;

    result_t pending_fault_reports[$];
    int      report_errors;

    // Stimulus shaping: each channel follows runs of one kind of sample.
    run_kind_t run_kind [CHANNELS];
    int        run_left [CHANNELS];
    int        burst_left;
    bit        gaps_on;
    int        hold_request;

    sensor_range_fault_detector dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_ch0  (s_sample_ch0),
        .s_sample_ch1  (s_sample_ch1),
        .s_sample_ch2  (s_sample_ch2),
        .s_sample_ch3  (s_sample_ch3),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fault_vec   (m_fault_vec),
        .m_low_vec     (m_low_vec),
        .m_high_vec    (m_high_vec),
        .m_changed     (m_changed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin : watchdog
        #3000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void clear_fault_model();
        int i;
        shadow_cfg.low_thr     = LOW_THR_RESET;
        shadow_cfg.high_thr    = HIGH_THR_RESET;
        shadow_cfg.assert_cnt  = ASSERT_RESET;
        shadow_cfg.recover_cnt = RECOVER_RESET;
        for (i = 0; i < CHANNELS; i++) begin
            bad_count[i]  = '0;
            good_count[i] = '0;
        end
        fault_active = '0;
        fault_low    = '0;
        fault_high   = '0;
        pending_fault_reports.delete();
    endfunction

    function automatic void apply_reg_write(input cfg_index_t idx,
                                            input logic [SAMPLE_BITS-1:0] value);
        case (idx)
            CFG_LOW_THR:     shadow_cfg.low_thr     = value;
            CFG_HIGH_THR:    shadow_cfg.high_thr    = value;
            CFG_ASSERT_CNT:  shadow_cfg.assert_cnt  = value[COUNT_BITS-1:0];
            CFG_RECOVER_CNT: shadow_cfg.recover_cnt = value[COUNT_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t apply_sample_set(
        input logic [CHANNELS-1:0][SAMPLE_BITS-1:0] set);
        result_t             r;
        logic [CHANNELS-1:0] was_active;
        logic [CHANNELS-1:0] was_low;
        logic [CHANNELS-1:0] was_high;
        logic                is_low;
        logic                is_high;
        int                  i;
        was_active = fault_active;
        was_low    = fault_low;
        was_high   = fault_high;
        for (i = 0; i < CHANNELS; i++) begin
            is_low  = set[i] <= shadow_cfg.low_thr;
            is_high = set[i] >= shadow_cfg.high_thr;
            if (is_low || is_high) begin
                good_count[i] = '0;
                if (bad_count[i] < shadow_cfg.assert_cnt) begin
                    bad_count[i] = bad_count[i] + 1'b1;
                end
                // An already active fault takes the cause of the latest bad sample.
                if (bad_count[i] >= shadow_cfg.assert_cnt) begin
                    fault_active[i] = 1'b1;
                    fault_low[i]    = is_low;
                    fault_high[i]   = !is_low;
                end
            end else begin
                bad_count[i] = '0;
                if (fault_active[i]) begin
                    if (good_count[i] < shadow_cfg.recover_cnt) begin
                        good_count[i] = good_count[i] + 1'b1;
                    end
                    if (good_count[i] >= shadow_cfg.recover_cnt) begin
                        fault_active[i] = 1'b0;
                        fault_low[i]    = 1'b0;
                        fault_high[i]   = 1'b0;
                        good_count[i]   = '0;
                    end
                end else begin
                    good_count[i] = '0;
                end
            end
        end
        r.fault_vec = fault_active;
        r.low_vec   = fault_low;
        r.high_vec  = fault_high;
        r.changed   = (was_active != fault_active) || (was_low != fault_low) ||
                      (was_high != fault_high);
        return r;
    endfunction

    function automatic void count_error(input string what);
        report_errors++;
        if (report_errors <= REPORT_LIMIT) begin
            $display("%0t: %s", $realtime, what);
        end
    endfunction

    // Predictions are made from the transfers seen at each rising edge, so
    // configuration and samples are applied in the order the block takes them:
    // a sample set taken at the same edge as a register write sees the old value.
    always @(posedge aclk) begin : fault_report_check
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_fault_model();
        end else begin
            if (s_valid && s_ready) begin
                pending_fault_reports.push_back(apply_sample_set(
                    {s_sample_ch3, s_sample_ch2, s_sample_ch1, s_sample_ch0}));
            end
            if (cfg_valid && cfg_ready) begin
                apply_reg_write(cfg_index_t'(cfg_index), cfg_data);
            end
            if (m_valid && m_ready) begin
                got.fault_vec = m_fault_vec;
                got.low_vec   = m_low_vec;
                got.high_vec  = m_high_vec;
                got.changed   = m_changed;
                if (pending_fault_reports.size() == 0) begin
                    count_error($sformatf("unexpected result active=%h low=%h high=%h changed=%b",
                        got.fault_vec, got.low_vec, got.high_vec, got.changed));
                end else begin
                    want = pending_fault_reports.pop_front();
                    if (got.fault_vec !== want.fault_vec ||
                        got.low_vec !== want.low_vec ||
                        got.high_vec !== want.high_vec ||
                        got.changed !== want.changed) begin
                        count_error($sformatf(
                            "expected active=%h low=%h high=%h changed=%b, got %h %h %h %b",
                            want.fault_vec, want.low_vec, want.high_vec, want.changed,
                            got.fault_vec, got.low_vec, got.high_vec, got.changed));
                    end
                end
            end
        end
    end

    // The receiver follows a 16-bit ready pattern that is redrawn now and then,
    // unless a long hold-off has been requested.
    initial begin : result_receiver
        int          hold_left;
        int          tick;
        logic [15:0] pattern;
        hold_left = 0;
        tick      = 0;
        pattern   = '1;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (tick % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       pattern = '1;
                    1:       pattern = 16'($urandom) | 16'h0001;
                    default: pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= pattern[tick % 16];
            end
            tick++;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] next_sample(input int ch);
        int need;
        int pick;
        int lo;
        int hi;
        if (run_left[ch] <= 0) begin
            pick = $urandom_range(0, 7);
            run_kind[ch] = (pick == 0) ? RUN_NOISE : (pick < 3) ? RUN_LOW :
                           (pick < 5) ? RUN_HIGH : RUN_GOOD;
            need = (run_kind[ch] == RUN_GOOD) ? int'(shadow_cfg.recover_cnt) :
                                                int'(shadow_cfg.assert_cnt);
            if (run_kind[ch] == RUN_NOISE || $urandom_range(0, 3) == 0) begin
                run_left[ch] = $urandom_range(1, 4);
            end else begin
                run_left[ch] = need + $urandom_range(0, 2);
            end
            if (run_left[ch] < 1) begin
                run_left[ch] = 1;
            end
        end
        run_left[ch]--;
        lo = int'(shadow_cfg.low_thr) + 1;
        hi = int'(shadow_cfg.high_thr) - 1;
        case (run_kind[ch])
            RUN_LOW: begin
                if ($urandom_range(0, 7) == 0) begin
                    return shadow_cfg.low_thr;
                end
                return SAMPLE_BITS'($urandom_range(0, shadow_cfg.low_thr));
            end
            RUN_HIGH: begin
                if ($urandom_range(0, 7) == 0) begin
                    return shadow_cfg.high_thr;
                end
                return SAMPLE_BITS'($urandom_range(shadow_cfg.high_thr, SAMPLE_MAX));
            end
            RUN_GOOD: begin
                // With crossed or touching thresholds every sample is bad.
                if (lo > hi) begin
                    return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
                end
                if ($urandom_range(0, 7) == 0) begin
                    return SAMPLE_BITS'(($urandom_range(0, 1) == 1) ? lo : hi);
                end
                return SAMPLE_BITS'($urandom_range(lo, hi));
            end
            default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    // Called at a falling edge; returns at a falling edge after the transfer.
    task automatic send_set(input logic [SAMPLE_BITS-1:0] c0, c1, c2, c3);
        s_valid      <= 1'b1;
        s_sample_ch0 <= c0;
        s_sample_ch1 <= c1;
        s_sample_ch2 <= c2;
        s_sample_ch3 <= c3;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge aclk);
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) :
                                                           $urandom_range(0, 10);
            end
        end
    endtask

    task automatic send_random_set();
        send_set(next_sample(0), next_sample(1), next_sample(2), next_sample(3));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_fault_reports.size() != 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [SAMPLE_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Count registers get random upper data bits, which the block must drop.
    task automatic program_regs(input logic [SAMPLE_BITS-1:0] low_thr, high_thr,
                                input logic [COUNT_BITS-1:0] assert_cnt, recover_cnt);
        write_reg(CFG_LOW_THR, low_thr);
        write_reg(CFG_HIGH_THR, high_thr);
        write_reg(CFG_ASSERT_CNT, {4'($urandom), assert_cnt});
        write_reg(CFG_RECOVER_CNT, {4'($urandom), recover_cnt});
    endtask

    task automatic test_default_thresholds();
        repeat (3) send_set(12'd0, 12'd4095, 12'd50, 12'd4045);
        // Faults already active switch their cause.
        send_set(12'd4095, 12'd0, 12'd4045, 12'd50);
        repeat (5) send_set(12'd51, 12'd4044, 12'd2048, 12'd4044);
        send_set(12'hAAA, 12'h555, 12'hFFF, 12'h000);
        wait_results_drained();
    endtask

    task automatic test_zero_counts();
        write_reg(CFG_ASSERT_CNT, 12'h000);
        write_reg(CFG_RECOVER_CNT, 12'h000);
        send_set(12'd0, 12'd2048, 12'd4095, 12'd2048);
        send_set(12'd2048, 12'd2048, 12'd2048, 12'd2048);
        send_set(12'd4095, 12'd0, 12'd2048, 12'd2048);
        wait_results_drained();
    endtask

    task automatic test_crossed_thresholds();
        // Every sample is bad here; where both limits are hit the cause is low.
        write_reg(CFG_LOW_THR, 12'd3000);
        write_reg(CFG_HIGH_THR, 12'd1000);
        write_reg(CFG_ASSERT_CNT, 12'hF01);
        write_reg(CFG_RECOVER_CNT, 12'h002);
        send_set(12'd2000, 12'd500, 12'd3500, 12'd0);
        send_set(12'd4095, 12'd1000, 12'd3000, 12'd2048);
        wait_results_drained();
    endtask

    task automatic test_counts_lowered();
        program_regs(12'd0, 12'd4095, 8'd255, 8'd255);
        repeat (3) send_set(12'd0, 12'd0, 12'd4095, 12'd4095);
        wait_results_drained();
        // The bad runs already reach the new count and raise the faults at once.
        write_reg(CFG_ASSERT_CNT, 12'h002);
        send_set(12'd0, 12'd4095, 12'd0, 12'd4095);
        repeat (3) send_set(12'd2048, 12'd1, 12'd4094, 12'd100);
        wait_results_drained();
        write_reg(CFG_RECOVER_CNT, 12'h001);
        send_set(12'd2048, 12'd2048, 12'd2048, 12'd2048);
        wait_results_drained();
    endtask

    task automatic test_output_backpressure();
        gaps_on = 1'b0;
        @(posedge aclk);
        hold_request = 300;
        @(negedge aclk);
        repeat (24) send_random_set();
        gaps_on = 1'b1;
        wait_results_drained();
    endtask

    task automatic test_random_phases();
        int phase;
        int i;
        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: program_regs(LOW_THR_RESET, HIGH_THR_RESET, ASSERT_RESET, RECOVER_RESET);
                6: program_regs(12'd0, 12'd4095, 8'd255, 8'd255);
                7: program_regs(SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)),
                                SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX)), 8'd1, 8'd0);
                default: program_regs(SAMPLE_BITS'($urandom_range(0, 600)),
                                      SAMPLE_BITS'($urandom_range(3500, SAMPLE_MAX)),
                                      COUNT_BITS'($urandom_range(0, 8)),
                                      COUNT_BITS'($urandom_range(0, 10)));
            endcase
            for (i = 0; i < CHANNELS; i++) begin
                run_left[i] = 0;
            end
            repeat ((phase == 6) ? 300 : 120) send_random_set();
            wait_results_drained();
        end
    endtask

    initial begin : stimulus
        int i;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_sample_ch0 = '0;
        s_sample_ch1 = '0;
        s_sample_ch2 = '0;
        s_sample_ch3 = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_LOW_THR;
        cfg_data     = '0;
        report_errors = 0;
        hold_request  = 0;
        burst_left    = 0;
        gaps_on       = 1'b1;
        for (i = 0; i < CHANNELS; i++) begin
            run_kind[i] = RUN_NOISE;
            run_left[i] = 0;
        end
        clear_fault_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_default_thresholds();
        test_zero_counts();
        test_crossed_thresholds();
        test_counts_lowered();
        test_output_backpressure();
        test_random_phases();

        wait_results_drained();
        repeat (20) @(posedge aclk);
        if (report_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
